FILE: rtl/core/sskbg_pkg.sv
// Shared types and constants for the stable key sort batch grouper.
// No dependencies; imported by the controller, datapath and top level.
package sskbg_pkg;

    localparam int MAX_GLYPHS_DEFAULT = 32;

    localparam int DEPTH_W   = 16;
    localparam int TEX_W     = 16;
    localparam int INDEX_W   = 5;
    localparam int BATCH_W   = 5;
    localparam int VOFF_W    = 8;
    localparam int MODE_W    = 2;
    localparam int KEY_W     = 16;
    localparam int PADDR_W   = 2;
    localparam int PDATA_W   = 32;

    localparam logic [VOFF_W-1:0] VERTS_PER_SPRITE = 8'd6;

    localparam logic [MODE_W-1:0] MODE_TEXTURE_ASC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEPTH_ASC   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEPTH_DESC  = 2'd2;

    localparam logic [PADDR_W-1:0] ADDR_SORT_MODE = 2'd0;

    // Controller to datapath
    typedef struct packed {
        logic scan;   // issue reads and compare records of one selection pass
        logic emit;   // present the selected record as a result
    } sskbg_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;  // all records of the pass read and compared
        logic last_pos;   // the result being emitted is the final one
    } sskbg_sts_t;

endpackage

FILE: rtl/core/stable_key_sort_batch_grouper.sv
// Top level of the stable key sort batch grouper: APB register and core wiring.
// Depends on sskbg_pkg, sskbg_ctrl and sskbg_dpath.
//
// Sprite records are taken one per cycle while busy is low (start high).
// A record without frame_end yields nothing; records past MaxGlyphs are
// dropped. The record with frame_end raises busy, and the n stored
// records are then handed out in stable key order, one result per
// record. Each result is found by a selection pass over the record store
// through its single read port: the records are read one by one, the last
// one read is compared, the pass is closed and the result is emitted;
// busy stays high and no record is taken until the last result is out.
// Each result is on the ports for exactly one cycle with result_valid high:
// the receiver cannot stall it and must take it then. last_out marks the
// final result; busy drops and the store is empty in that same cycle.
// sort_mode is sampled when frame_end is taken; write it at byte address 0
// while the block is idle.
module stable_key_sort_batch_grouper
#(
    parameter int MaxGlyphs = sskbg_pkg::MAX_GLYPHS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    // record input
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [sskbg_pkg::DEPTH_W-1:0]   depth,
    input  logic        [sskbg_pkg::TEX_W-1:0]     texture_id,
    input  logic                                   frame_end,
    // results
    output logic                                   result_valid,
    output logic        [sskbg_pkg::INDEX_W-1:0]   glyph_index,
    output logic        [sskbg_pkg::TEX_W-1:0]     texture_out,
    output logic        [sskbg_pkg::BATCH_W-1:0]   batch_number,
    output logic        [sskbg_pkg::VOFF_W-1:0]    batch_vertex_offset,
    output logic                                   new_batch,
    output logic                                   last_out,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [sskbg_pkg::PADDR_W-1:0]   paddr,
    input  logic        [sskbg_pkg::PDATA_W-1:0]   pwdata,
    output logic        [sskbg_pkg::PDATA_W-1:0]   prdata,
    output logic                                   pready
);
    import sskbg_pkg::*;

    logic              accept;
    logic [MODE_W-1:0] sort_mode_reg;
    sskbg_cmd_t        cmd;
    sskbg_sts_t        sts;

    assign accept = start && !busy;
    assign pready = 1'b1;

    // Register file: only sort_mode, anything else reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_mode_reg <= MODE_TEXTURE_ASC;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_SORT_MODE))
        begin
            sort_mode_reg <= pwdata[MODE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_SORT_MODE)
        begin
            prdata = PDATA_W'(sort_mode_reg);
        end
    end

    sskbg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .frame_end (frame_end),
        .sts       (sts),
        .cmd       (cmd),
        .busy      (busy)
    );

    sskbg_dpath
    #(
        .MaxGlyphs (MaxGlyphs)
    )
    u_dpath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .depth               (depth),
        .texture_id          (texture_id),
        .frame_end           (frame_end),
        .sort_mode           (sort_mode_reg),
        .cmd                 (cmd),
        .sts                 (sts),
        .result_valid        (result_valid),
        .glyph_index         (glyph_index),
        .texture_out         (texture_out),
        .batch_number        (batch_number),
        .batch_vertex_offset (batch_vertex_offset),
        .new_batch           (new_batch),
        .last_out            (last_out)
    );

endmodule

FILE: rtl/core/sskbg_ctrl.sv
// Sequencer for the stable key sort batch grouper: load, scan and emit phases.
// Depends on sskbg_pkg for the command and status types.
module sskbg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic                  frame_end,
    input  sskbg_pkg::sskbg_sts_t sts,
    output sskbg_pkg::sskbg_cmd_t cmd,
    output logic                  busy
);
    import sskbg_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept && frame_end)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = sts.last_pos ? ST_LOAD : ST_SCAN;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_LOAD);

endmodule

FILE: rtl/core/sskbg_dpath.sv
// Record store, selection compare and batch bookkeeping for the grouper.
// Depends on sskbg_pkg for widths, sort mode codes and the command/status types.
module sskbg_dpath
#(
    parameter int MaxGlyphs = sskbg_pkg::MAX_GLYPHS_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic signed [sskbg_pkg::DEPTH_W-1:0]   depth,
    input  logic        [sskbg_pkg::TEX_W-1:0]     texture_id,
    input  logic                                   frame_end,
    input  logic        [sskbg_pkg::MODE_W-1:0]    sort_mode,
    input  sskbg_pkg::sskbg_cmd_t                  cmd,
    output sskbg_pkg::sskbg_sts_t                  sts,
    output logic                                   result_valid,
    output logic        [sskbg_pkg::INDEX_W-1:0]   glyph_index,
    output logic        [sskbg_pkg::TEX_W-1:0]     texture_out,
    output logic        [sskbg_pkg::BATCH_W-1:0]   batch_number,
    output logic        [sskbg_pkg::VOFF_W-1:0]    batch_vertex_offset,
    output logic                                   new_batch,
    output logic                                   last_out
);
    import sskbg_pkg::*;

    localparam int IdxW  = $clog2(MaxGlyphs);
    localparam int CntW  = $clog2(MaxGlyphs + 1);
    localparam int PairW = KEY_W + IdxW;
    localparam logic [CntW-1:0] CntMax = CntW'(MaxGlyphs);
    localparam logic [CntW-1:0] CntOne = CntW'(1);

    // Record store: one write port at load, one registered read port for scans
    logic [DEPTH_W-1:0] depth_mem [MaxGlyphs];
    logic [TEX_W-1:0]   tex_mem   [MaxGlyphs];

    logic [CntW-1:0]    count_reg;
    logic [MODE_W-1:0]  mode_reg;
    logic [CntW-1:0]    issue_reg;
    logic               rd_pend_reg;
    logic [IdxW-1:0]    rd_idx_reg;
    logic [DEPTH_W-1:0] rd_depth_reg;
    logic [TEX_W-1:0]   rd_tex_reg;

    logic [PairW-1:0]   best_pair_reg;
    logic [TEX_W-1:0]   best_tex_reg;
    logic               have_best_reg;
    logic [PairW-1:0]   last_pair_reg;
    logic               have_last_reg;

    logic [CntW-1:0]    pos_reg;
    logic [TEX_W-1:0]   prev_tex_reg;
    logic [BATCH_W-1:0] batch_reg;
    logic [VOFF_W-1:0]  batch_vert_reg;
    logic [VOFF_W-1:0]  pos_vert_reg;

    logic               store_wr;
    logic               frame_go;
    logic               issue_rd;
    logic [KEY_W-1:0]   rd_key;
    logic [PairW-1:0]   rd_pair;
    logic               take;
    logic               fresh;
    logic [BATCH_W-1:0] batch_now;
    logic [VOFF_W-1:0]  vert_now;

    assign store_wr = accept && (count_reg < CntMax);
    assign frame_go = accept && frame_end;
    assign issue_rd = cmd.scan && (issue_reg != count_reg);

    // Sort key: ties fall through to the arrival index in the low bits
    always_comb
    begin
        case (mode_reg)
            MODE_TEXTURE_ASC: rd_key = rd_tex_reg;
            MODE_DEPTH_ASC:   rd_key = rd_depth_reg ^ 16'h8000;
            MODE_DEPTH_DESC:  rd_key = ~(rd_depth_reg ^ 16'h8000);
            default:          rd_key = '0;
        endcase
    end

    assign rd_pair = {rd_key, rd_idx_reg};
    assign take    = rd_pend_reg
                   && (!have_last_reg || (rd_pair > last_pair_reg))
                   && (!have_best_reg || (rd_pair < best_pair_reg));

    assign fresh     = (pos_reg == '0) || (best_tex_reg != prev_tex_reg);
    assign batch_now = (fresh && (pos_reg != '0)) ? batch_reg + BATCH_W'(1) : batch_reg;
    assign vert_now  = fresh ? pos_vert_reg : batch_vert_reg;

    assign sts.scan_done = (issue_reg == count_reg) && !rd_pend_reg;
    assign sts.last_pos  = ((pos_reg + CntOne) == count_reg);

    always_ff @(posedge clk)
    begin
        if (store_wr)
        begin
            depth_mem[count_reg[IdxW-1:0]] <= depth;
            tex_mem[count_reg[IdxW-1:0]]   <= texture_id;
        end
        if (issue_rd)
        begin
            rd_depth_reg <= depth_mem[issue_reg[IdxW-1:0]];
            rd_tex_reg   <= tex_mem[issue_reg[IdxW-1:0]];
            rd_idx_reg   <= issue_reg[IdxW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_pair_reg <= rd_pair;
            best_tex_reg  <= rd_tex_reg;
        end
        if (frame_go)
        begin
            mode_reg <= sort_mode;
        end
        if (cmd.emit)
        begin
            last_pair_reg       <= best_pair_reg;
            prev_tex_reg        <= best_tex_reg;
            batch_reg           <= batch_now;
            batch_vert_reg      <= vert_now;
            pos_vert_reg        <= pos_vert_reg + VERTS_PER_SPRITE;
            glyph_index         <= INDEX_W'(best_pair_reg[IdxW-1:0]);
            texture_out         <= best_tex_reg;
            batch_number        <= batch_now;
            batch_vertex_offset <= vert_now;
            new_batch           <= fresh;
            last_out            <= sts.last_pos;
        end
        else if (frame_go)
        begin
            batch_reg    <= '0;
            pos_vert_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            issue_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            have_best_reg <= 1'b0;
            have_last_reg <= 1'b0;
            pos_reg       <= '0;
            result_valid  <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
            rd_pend_reg  <= issue_rd;
            if (store_wr)
            begin
                count_reg <= count_reg + CntOne;
            end
            if (issue_rd)
            begin
                issue_reg <= issue_reg + CntOne;
            end
            if (take)
            begin
                have_best_reg <= 1'b1;
            end
            if (frame_go)
            begin
                issue_reg     <= '0;
                have_best_reg <= 1'b0;
                have_last_reg <= 1'b0;
                pos_reg       <= '0;
            end
            if (cmd.emit)
            begin
                // Restart the selection pass just past the record handed out
                issue_reg     <= '0;
                have_best_reg <= 1'b0;
                have_last_reg <= 1'b1;
                pos_reg       <= pos_reg + CntOne;
                if (sts.last_pos)
                begin
                    count_reg <= '0;
                end
            end
        end
    end

endmodule
